// ===== rtl/core/fbvg_pkg.sv =====
`default_nettype none

package fbvg_pkg;

   // input word kinds
   typedef logic [1:0] mode_type;
   localparam mode_type MODE_TICK  = 2'd0;
   localparam mode_type MODE_PIXEL = 2'd1;
   localparam mode_type MODE_CLEAR = 2'd2;

   // frame timing phases
   typedef logic [2:0] phase_type;
   localparam phase_type PH_SYNC  = 3'd0;
   localparam phase_type PH_PIX   = 3'd1;
   localparam phase_type PH_PLOW  = 3'd2;
   localparam phase_type PH_PHIGH = 3'd3;
   localparam phase_type PH_PAUSE = 3'd4;

   // configuration register indexes
   typedef logic [2:0] csr_index_type;
   localparam csr_index_type CSR_SYNC_TICKS       = 3'd0;
   localparam csr_index_type CSR_PIXEL_TICKS      = 3'd1;
   localparam csr_index_type CSR_BLANK_HIGH_TICKS = 3'd2;
   localparam csr_index_type CSR_VSYNC_PULSES     = 3'd3;
   localparam csr_index_type CSR_PAUSE_TICKS      = 3'd4;

   localparam int CSR_DATA_W = 23;
   localparam int TICK_W     = 23;

   localparam logic [9:0]  SYNC_TICKS_RST       = 10'd47;
   localparam logic [7:0]  PIXEL_TICKS_RST      = 8'd5;
   localparam logic [11:0] BLANK_HIGH_TICKS_RST = 12'd588;
   localparam logic [9:0]  VSYNC_PULSES_RST     = 10'd166;
   localparam logic [22:0] PAUSE_TICKS_RST      = 23'd5000000;

   // sequencer states
   typedef logic [1:0] op_type;
   localparam op_type OP_IDLE  = 2'd0;
   localparam op_type OP_WRITE = 2'd1;
   localparam op_type OP_CLEAR = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/core/framebuffer_video_generator_unit.sv =====
`default_nettype none

// One-bit framebuffer with a single-wire video output. A tick word is taken every cycle while busy
// is low and advances the frame timing by one tick; each word gives one response on the cycle
// after it is accepted, and the receiver cannot stall it. A pixel write inside the screen reads
// the byte, then writes it back, with busy high during the write-back; one outside the screen
// leaves busy low. A screen clear sweeps the store one byte a cycle through its single write
// port. After reset the same sweep clears the store with busy high; configuration writes are
// taken at any time.
module framebuffer_video_generator_unit #(
   parameter int SCREEN_WIDTH  = 128,
   parameter int SCREEN_HEIGHT = 64
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   output logic                         busy,
   input  wire fbvg_pkg::mode_type      req_mode,
   input  wire [7:0]                    req_x,
   input  wire [7:0]                    req_y,
   input  wire                          req_color,
   output logic                         rsp_strobe,
   output logic                         rsp_video_level,
   output fbvg_pkg::phase_type          rsp_phase,
   output logic [5:0]                   rsp_line,
   output logic                         rsp_frame_start,
   output logic                         rsp_pixel_ignored,
   input  wire                          csr_wr_en,
   input  wire fbvg_pkg::csr_index_type csr_index,
   input  wire [fbvg_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import fbvg_pkg::*;

   localparam int ROW_BYTES   = SCREEN_WIDTH / 8;
   localparam int STORE_BYTES = ROW_BYTES * SCREEN_HEIGHT;
   localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
   localparam int COL_W       = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
   localparam int LINE_W      = $clog2(SCREEN_HEIGHT + 1);

   localparam logic [COL_W:0]    ROW_BYTES_V = (COL_W + 1)'(ROW_BYTES);
   localparam logic [LINE_W:0]   HEIGHT_V    = (LINE_W + 1)'(SCREEN_HEIGHT);
   localparam logic [8:0]        WIDTH_V     = 9'(SCREEN_WIDTH);
   localparam logic [8:0]        HEIGHT_Y    = 9'(SCREEN_HEIGHT);
   localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(STORE_BYTES - 1);

   function automatic logic [ADDR_W-1:0] row_addr(input logic [31:0] row,
                                                 input logic [31:0] col);
      logic [31:0] full;
      full = row * 32'(ROW_BYTES) + col;
      return full[ADDR_W-1:0];
   endfunction

   // configuration
   logic [9:0]  sync_ticks_ff;
   logic [7:0]  pixel_ticks_ff;
   logic [11:0] blank_high_ticks_ff;
   logic [9:0]  vsync_pulses_ff;
   logic [22:0] pause_ticks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ticks_ff       <= SYNC_TICKS_RST;
         pixel_ticks_ff      <= PIXEL_TICKS_RST;
         blank_high_ticks_ff <= BLANK_HIGH_TICKS_RST;
         vsync_pulses_ff     <= VSYNC_PULSES_RST;
         pause_ticks_ff      <= PAUSE_TICKS_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SYNC_TICKS:       sync_ticks_ff       <= csr_wdata[9:0];
            CSR_PIXEL_TICKS:      pixel_ticks_ff      <= csr_wdata[7:0];
            CSR_BLANK_HIGH_TICKS: blank_high_ticks_ff <= csr_wdata[11:0];
            CSR_VSYNC_PULSES:     vsync_pulses_ff     <= csr_wdata[9:0];
            CSR_PAUSE_TICKS:      pause_ticks_ff      <= csr_wdata[22:0];
            default: ;
         endcase
      end
   end

   // sequencer
   op_type            op_ff, op_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [7:0]        fill_ff, fill_in;
   logic [ADDR_W-1:0] wa_ff, wa_in;
   logic [7:0]        mask_ff, mask_in;
   logic              color_ff, color_in;

   // timing state
   phase_type         phase_ff, phase_in;
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [2:0]        bit_ff, bit_in;
   logic [9:0]        pulse_ff, pulse_in;

   logic accept, tick_en, pix_en, clr_en, outside;

   assign busy    = (op_ff != OP_IDLE);
   assign accept  = start && !busy;
   assign tick_en = accept && (req_mode == MODE_TICK);
   assign outside = ({1'b0, req_x} >= WIDTH_V) || ({1'b0, req_y} >= HEIGHT_Y);
   assign pix_en  = accept && (req_mode == MODE_PIXEL) && !outside;
   assign clr_en  = accept && (req_mode == MODE_CLEAR);

   // frame store: port A feeds the video, port B the pixel read-modify-write
   logic [7:0]        mem [STORE_BYTES];
   logic [7:0]        rd_a_ff, rd_b_ff;
   logic              fwd_ff;
   logic [7:0]        fwd_data_ff;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr, vid_addr, pix_addr;
   logic [7:0]        wr_data, vid_byte;

   assign wr_en   = (op_ff == OP_WRITE) || (op_ff == OP_CLEAR);
   assign wr_addr = (op_ff == OP_WRITE) ? wa_ff : clr_addr_ff;
   assign wr_data = (op_ff == OP_WRITE)
                    ? (color_ff ? (rd_b_ff | mask_ff) : (rd_b_ff & ~mask_ff))
                    : fill_ff;
   assign pix_addr = row_addr(32'(req_y), 32'(req_x[7:3]));
   // fetch the byte under the next timing position, so it is ready with that state
   assign vid_addr = row_addr(({1'b0, line_in} < HEIGHT_V) ? 32'(line_in) : 32'd0,
                              32'(col_in));
   assign vid_byte = fwd_ff ? fwd_data_ff : rd_a_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff     <= mem[vid_addr];
      rd_b_ff     <= mem[pix_addr];
      fwd_ff      <= wr_en && (wr_addr == vid_addr);
      fwd_data_ff <= wr_data;
   end

   always_comb begin
      op_in       = op_ff;
      clr_addr_in = clr_addr_ff;
      fill_in     = fill_ff;
      wa_in       = wa_ff;
      mask_in     = mask_ff;
      color_in    = color_ff;
      unique case (op_ff)
         OP_WRITE: op_in = OP_IDLE;
         OP_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == LAST_ADDR) begin
               op_in = OP_IDLE;
            end
         end
         default: begin
            if (pix_en) begin
               op_in    = OP_WRITE;
               wa_in    = pix_addr;
               mask_in  = 8'h80 >> req_x[2:0];
               color_in = req_color;
            end else if (clr_en) begin
               op_in       = OP_CLEAR;
               clr_addr_in = '0;
               fill_in     = {8{req_color}};
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff       <= OP_CLEAR;
         clr_addr_ff <= '0;
         fill_ff     <= 8'h00;
      end else begin
         op_ff       <= op_in;
         clr_addr_ff <= clr_addr_in;
         fill_ff     <= fill_in;
      end
      wa_ff    <= wa_in;
      mask_ff  <= mask_in;
      color_ff <= color_in;
   end

   // timing
   logic [TICK_W-1:0] phase_len;
   logic [TICK_W:0]   tick_inc;
   logic [COL_W:0]    col_inc;
   logic [LINE_W:0]   line_inc;
   logic [10:0]       pulse_inc;
   logic              phase_done;

   always_comb begin
      unique case (phase_ff)
         PH_SYNC, PH_PLOW: phase_len = TICK_W'(sync_ticks_ff);
         PH_PIX:           phase_len = TICK_W'(pixel_ticks_ff);
         PH_PHIGH:         phase_len = TICK_W'(blank_high_ticks_ff);
         default:          phase_len = pause_ticks_ff;
      endcase
      if (phase_len == '0) begin
         phase_len = TICK_W'(1);
      end
   end

   assign tick_inc   = {1'b0, tick_ff} + 1'b1;
   assign col_inc    = {1'b0, col_ff} + 1'b1;
   assign line_inc   = {1'b0, line_ff} + 1'b1;
   assign pulse_inc  = {1'b0, pulse_ff} + 1'b1;
   assign phase_done = tick_inc >= {1'b0, phase_len};

   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      line_in  = line_ff;
      col_in   = col_ff;
      bit_in   = bit_ff;
      pulse_in = pulse_ff;
      if (tick_en) begin
         if (!phase_done) begin
            tick_in = tick_inc[TICK_W-1:0];
         end else begin
            tick_in = '0;
            unique case (phase_ff)
               PH_SYNC: begin
                  phase_in = PH_PIX;
                  col_in   = '0;
                  bit_in   = '0;
               end
               PH_PIX: begin
                  bit_in = bit_ff + 1'b1;
                  if (bit_ff == 3'd7) begin
                     if (col_inc < ROW_BYTES_V) begin
                        col_in = col_inc[COL_W-1:0];
                     end else begin
                        col_in  = '0;
                        line_in = line_inc[LINE_W-1:0];
                        if (line_inc < HEIGHT_V) begin
                           phase_in = PH_SYNC;
                        end else begin
                           pulse_in = '0;
                           if (vsync_pulses_ff != '0) begin
                              phase_in = PH_PLOW;
                           end else if (pause_ticks_ff != '0) begin
                              phase_in = PH_PAUSE;
                           end else begin
                              phase_in = PH_SYNC;
                              line_in  = '0;
                           end
                        end
                     end
                  end
               end
               PH_PLOW: phase_in = PH_PHIGH;
               PH_PHIGH: begin
                  pulse_in = pulse_inc[9:0];
                  if (pulse_inc < {1'b0, vsync_pulses_ff}) begin
                     phase_in = PH_PLOW;
                  end else if (pause_ticks_ff != '0) begin
                     phase_in = PH_PAUSE;
                  end else begin
                     phase_in = PH_SYNC;
                     line_in  = '0;
                  end
               end
               default: begin
                  phase_in = PH_SYNC;
                  line_in  = '0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SYNC;
         tick_ff  <= '0;
         line_ff  <= '0;
         col_ff   <= '0;
         bit_ff   <= '0;
         pulse_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
         bit_ff   <= bit_in;
         pulse_ff <= pulse_in;
      end
   end

   // response word
   logic             level_ff, level_in;
   logic             cur_level;
   logic [LINE_W+5:0] line_ext;

   assign line_ext = {6'd0, line_ff};

   always_comb begin
      unique case (phase_ff)
         PH_PIX:   cur_level = vid_byte[3'd7 - bit_ff];
         PH_PHIGH: cur_level = 1'b1;
         default:  cur_level = 1'b0;
      endcase
      level_in = tick_en ? cur_level : level_ff;
   end

   logic strobe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff  <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         level_ff  <= level_in;
         strobe_ff <= accept;
      end
      if (accept) begin
         rsp_video_level   <= level_in;
         rsp_phase         <= phase_ff;
         rsp_line          <= (phase_ff == PH_SYNC || phase_ff == PH_PIX)
                              ? line_ext[5:0] : 6'd0;
         rsp_frame_start   <= tick_en && (phase_ff == PH_SYNC) && (line_ff == '0)
                              && (tick_ff == '0);
         rsp_pixel_ignored <= (req_mode == MODE_PIXEL) && outside;
      end
   end

   assign rsp_strobe = strobe_ff;

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
module tb_top;
   import fbvg_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SCREEN_W    = 128;
   localparam int SCREEN_H    = 64;
   localparam int ROW_BYTES   = SCREEN_W / 8;
   localparam int STORE_BYTES = ROW_BYTES * SCREEN_H;
   localparam int STALL_LIMIT = 8000;
   localparam int MAX_REPORTS = 50;

   // mode 3 has no function; index 7 maps to no register
   localparam mode_type      MODE_UNUSED = 2'd3;
   localparam csr_index_type CSR_UNUSED  = 3'd7;

   typedef struct packed {
      logic       level;
      phase_type  phase;
      logic [5:0] line;
      logic       frame_start;
      logic       ignored;
   } video_word_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  start     = 1'b0;
   mode_type              req_mode  = MODE_TICK;
   logic [7:0]            req_x     = 8'd0;
   logic [7:0]            req_y     = 8'd0;
   logic                  req_color = 1'b0;
   logic                  csr_wr_en = 1'b0;
   csr_index_type         csr_index = CSR_SYNC_TICKS;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic       busy;
   logic       rsp_strobe;
   logic       rsp_video_level;
   phase_type  rsp_phase;
   logic [5:0] rsp_line;
   logic       rsp_frame_start;
   logic       rsp_pixel_ignored;

   framebuffer_video_generator_unit #(
      .SCREEN_WIDTH  (SCREEN_W),
      .SCREEN_HEIGHT (SCREEN_H)
   ) uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_x             (req_x),
      .req_y             (req_y),
      .req_color         (req_color),
      .rsp_strobe        (rsp_strobe),
      .rsp_video_level   (rsp_video_level),
      .rsp_phase         (rsp_phase),
      .rsp_line          (rsp_line),
      .rsp_frame_start   (rsp_frame_start),
      .rsp_pixel_ignored (rsp_pixel_ignored),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------- frame model
   logic [7:0]  fb_mem [STORE_BYTES];
   phase_type   tm_phase;
   int          tm_ticks, tm_line, tm_byte, tm_bit, tm_pulse;
   logic        tm_level;
   logic [9:0]  r_sync;
   logic [7:0]  r_pixel;
   logic [11:0] r_blank;
   logic [9:0]  r_vsync;
   logic [22:0] r_pause;

   video_word_type pending_words[$];
   int             pending_cnt = 0;
   int             mismatches  = 0;
   int             idle_cycles = 0;

   function automatic int min_one(int v);
      return (v == 0) ? 1 : v;
   endfunction

   function void reset_video_model();
      foreach (fb_mem[i]) fb_mem[i] = 8'h00;
      tm_phase = PH_SYNC;
      tm_ticks = 0;
      tm_line  = 0;
      tm_byte  = 0;
      tm_bit   = 0;
      tm_pulse = 0;
      tm_level = 1'b0;
      r_sync   = SYNC_TICKS_RST;
      r_pixel  = PIXEL_TICKS_RST;
      r_blank  = BLANK_HIGH_TICKS_RST;
      r_vsync  = VSYNC_PULSES_RST;
      r_pause  = PAUSE_TICKS_RST;
   endfunction

   function void apply_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_SYNC_TICKS:       r_sync  = data[9:0];
         CSR_PIXEL_TICKS:      r_pixel = data[7:0];
         CSR_BLANK_HIGH_TICKS: r_blank = data[11:0];
         CSR_VSYNC_PULSES:     r_vsync = data[9:0];
         CSR_PAUSE_TICKS:      r_pause = data[22:0];
         default: ;
      endcase
   endfunction

   function int phase_ticks();
      case (tm_phase)
         PH_SYNC, PH_PLOW: return min_one(int'(r_sync));
         PH_PIX:           return min_one(int'(r_pixel));
         PH_PHIGH:         return min_one(int'(r_blank));
         default:          return min_one(int'(r_pause));
      endcase
   endfunction

   function void end_of_frame();
      if (r_pause != 0) begin
         tm_phase = PH_PAUSE;
      end else begin
         tm_phase = PH_SYNC;
         tm_line  = 0;
      end
   endfunction

   function void advance_timing();
      tm_ticks++;
      if (tm_ticks < phase_ticks()) return;
      tm_ticks = 0;
      case (tm_phase)
         PH_SYNC: begin
            tm_phase = PH_PIX;
            tm_byte  = 0;
            tm_bit   = 0;
         end
         PH_PIX: begin
            tm_bit++;
            if (tm_bit == 8) begin
               tm_bit = 0;
               tm_byte++;
               if (tm_byte == ROW_BYTES) begin
                  tm_byte = 0;
                  tm_line++;
                  if (tm_line < SCREEN_H) begin
                     tm_phase = PH_SYNC;
                  end else begin
                     tm_pulse = 0;
                     if (r_vsync != 0) tm_phase = PH_PLOW;
                     else end_of_frame();
                  end
               end
            end
         end
         PH_PLOW: tm_phase = PH_PHIGH;
         PH_PHIGH: begin
            tm_pulse++;
            if (tm_pulse < r_vsync) tm_phase = PH_PLOW;
            else end_of_frame();
         end
         default: begin
            tm_phase = PH_SYNC;
            tm_line  = 0;
         end
      endcase
   endfunction

   function logic pixel_level();
      logic [7:0] b;
      if (tm_phase == PH_PIX) begin
         b = fb_mem[tm_line * ROW_BYTES + tm_byte];
         return b[7 - tm_bit];
      end
      return (tm_phase == PH_PHIGH);
   endfunction

   function video_word_type next_video_word(mode_type m, logic [7:0] x, logic [7:0] y,
                                            logic c);
      video_word_type w;
      int             a;
      w = '0;
      case (m)
         MODE_TICK: begin
            w.frame_start = (tm_phase == PH_SYNC && tm_line == 0 && tm_ticks == 0);
            tm_level = pixel_level();
         end
         MODE_PIXEL: begin
            if (x >= SCREEN_W || y >= SCREEN_H) begin
               w.ignored = 1'b1;
            end else begin
               a = int'(y) * ROW_BYTES + int'(x[7:3]);
               fb_mem[a][3'd7 - x[2:0]] = c;
            end
         end
         MODE_CLEAR: foreach (fb_mem[i]) fb_mem[i] = {8{c}};
         default: ;
      endcase
      w.level = tm_level;
      w.phase = tm_phase;
      w.line  = (tm_phase == PH_SYNC || tm_phase == PH_PIX) ? tm_line[5:0] : 6'd0;
      if (m == MODE_TICK) advance_timing();
      return w;
   endfunction

   // ---------------------------------------------------------------- checking
   task flag_mismatch(string what, int got, int want);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
   endtask

   always @(posedge clock) begin
      video_word_type want_w;
      video_word_type fresh_w;
      if (reset) begin
         reset_video_model();
         pending_words.delete();
      end else begin
         if (rsp_strobe) begin
            if (pending_words.size() == 0) begin
               flag_mismatch("word with nothing pending", 1, 0);
            end else begin
               want_w = pending_words.pop_front();
               if (rsp_video_level !== want_w.level)
                  flag_mismatch("video_level", int'(rsp_video_level), int'(want_w.level));
               if (rsp_phase !== want_w.phase)
                  flag_mismatch("phase", int'(rsp_phase), int'(want_w.phase));
               if (rsp_line !== want_w.line)
                  flag_mismatch("line", int'(rsp_line), int'(want_w.line));
               if (rsp_frame_start !== want_w.frame_start)
                  flag_mismatch("frame_start", int'(rsp_frame_start),
                                int'(want_w.frame_start));
               if (rsp_pixel_ignored !== want_w.ignored)
                  flag_mismatch("pixel_ignored", int'(rsp_pixel_ignored),
                                int'(want_w.ignored));
            end
         end
         // a word taken on the same edge as a register write still sees the old value
         if (start && !busy) begin
            fresh_w = next_video_word(req_mode, req_x, req_y, req_color);
            pending_words.push_back(fresh_w);
         end
         if (csr_wr_en) apply_csr(csr_index, csr_wdata);
      end
      pending_cnt <= pending_words.size();
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- driving
   // start stays high after an accept; only pause_sender and drain lower it
   task automatic send_word(mode_type m, logic [7:0] x, logic [7:0] y, logic c);
      @(negedge clock);
      start     <= 1'b1;
      req_mode  <= m;
      req_x     <= x;
      req_y     <= y;
      req_color <= c;
      do @(posedge clock); while (busy);
   endtask

   task automatic pause_sender(int n);
      @(negedge clock) start <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic random_gap(int pct);
      if ($urandom_range(0, 99) < pct) pause_sender(int'($urandom_range(1, 16)));
   endtask

   task automatic drain();
      @(negedge clock) start <= 1'b0;
      do @(posedge clock); while (pending_cnt != 0 || busy);
   endtask

   task automatic csr_write(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic csr_done();
      @(negedge clock) csr_wr_en <= 1'b0;
   endtask

   task automatic set_timing(logic [CSR_DATA_W-1:0] sync_t, logic [CSR_DATA_W-1:0] pix_t,
                             logic [CSR_DATA_W-1:0] blank_t, logic [CSR_DATA_W-1:0] pulses,
                             logic [CSR_DATA_W-1:0] pause_t);
      drain();
      csr_write(CSR_SYNC_TICKS, sync_t);
      csr_write(CSR_PIXEL_TICKS, pix_t);
      csr_write(CSR_BLANK_HIGH_TICKS, blank_t);
      csr_write(CSR_VSYNC_PULSES, pulses);
      csr_write(CSR_PAUSE_TICKS, pause_t);
      csr_done();
   endtask

   task automatic send_random_word();
      int         r;
      logic [7:0] x;
      logic [7:0] y;
      mode_type   m;
      r = $urandom_range(0, 99);
      if (r < 70)      m = MODE_TICK;
      else if (r < 93) m = MODE_PIXEL;
      else if (r < 97) m = MODE_CLEAR;
      else             m = MODE_UNUSED;
      x = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, SCREEN_W - 1))
                                      : 8'($urandom_range(0, 255));
      y = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, SCREEN_H - 1))
                                      : 8'($urandom_range(0, 255));
      send_word(m, x, y, 1'($urandom_range(0, 1)));
   endtask

   // mostly ticks, with in-screen writes so lines carry content
   task automatic send_walk_word();
      if ($urandom_range(0, 19) == 0)
         send_word(MODE_PIXEL, 8'($urandom_range(0, SCREEN_W - 1)),
                   8'($urandom_range(0, SCREEN_H - 1)), 1'($urandom_range(0, 1)));
      else
         send_word(MODE_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)));
   endtask

   // ---------------------------------------------------------------- tests
   task automatic test_reset_and_edges();
      send_word(MODE_TICK, 8'd0, 8'd0, 1'b0);       // first tick after reset opens the frame
      send_word(MODE_PIXEL, 8'd0, 8'd0, 1'b1);
      send_word(MODE_PIXEL, 8'd127, 8'd63, 1'b1);
      send_word(MODE_PIXEL, 8'd128, 8'd0, 1'b1);    // just right of the screen
      send_word(MODE_PIXEL, 8'd0, 8'd64, 1'b1);     // just below the screen
      send_word(MODE_PIXEL, 8'd255, 8'd255, 1'b0);
      send_word(MODE_PIXEL, 8'd7, 8'd0, 1'b1);
      send_word(MODE_PIXEL, 8'd8, 8'd0, 1'b0);
      send_word(MODE_UNUSED, 8'hFF, 8'hFF, 1'b1);
      send_word(MODE_CLEAR, 8'd0, 8'd0, 1'b1);
      send_word(MODE_TICK, 8'd0, 8'd0, 1'b0);
      send_word(MODE_CLEAR, 8'hFF, 8'hFF, 1'b0);
      send_word(MODE_TICK, 8'd0, 8'd0, 1'b0);
      // elapsed sync already past one tick: the cut drops into line zero pixels
      set_timing(23'd1, 23'd1, 23'd1, 23'd1, 23'd1);
      send_word(MODE_PIXEL, 8'd0, 8'd0, 1'b1);
      send_word(MODE_PIXEL, 8'd2, 8'd0, 1'b1);
      send_word(MODE_PIXEL, 8'd4, 8'd0, 1'b1);
      repeat (8) send_word(MODE_TICK, 8'd0, 8'd0, 1'b0);
   endtask

   task automatic test_register_extremes();
      set_timing('1, '1, '1, '1, '1);
      csr_write(CSR_UNUSED, '1);
      csr_done();
      repeat (20) begin
         random_gap(20);
         send_random_word();
      end
   endtask

   // zero durations act as one tick each
   task automatic test_zero_durations();
      set_timing('0, '0, '0, '0, '0);
      repeat (60) begin
         random_gap(2);
         send_walk_word();
      end
   endtask

   // shortening a duration below the elapsed count ends the phase on the next tick
   task automatic test_phase_cut();
      set_timing('1, '1, '1, '1, '1);
      repeat (30) send_word(MODE_TICK, 8'd0, 8'd0, 1'b0);
      drain();
      csr_write(CSR_SYNC_TICKS, 23'd5);
      csr_write(CSR_PIXEL_TICKS, 23'd5);
      csr_done();
      repeat (30) send_walk_word();
   endtask

   task automatic test_random_traffic();
      int gap_pct;
      for (int chunk = 0; chunk < 8; chunk++) begin
         set_timing(($urandom_range(0, 3) == 0) ? 23'($urandom_range(0, 1023))
                                                : 23'($urandom_range(0, 12)),
                    ($urandom_range(0, 3) == 0) ? 23'($urandom_range(0, 255))
                                                : 23'($urandom_range(0, 3)),
                    ($urandom_range(0, 3) == 0) ? 23'($urandom_range(0, 4095))
                                                : 23'($urandom_range(0, 40)),
                    ($urandom_range(0, 3) == 0) ? 23'($urandom_range(0, 1023))
                                                : 23'($urandom_range(0, 4)),
                    ($urandom_range(0, 3) == 0) ? 23'($urandom_range(0, 8388607))
                                                : 23'($urandom_range(0, 60)));
         gap_pct = (chunk == 3 || chunk == 7) ? 0 : 15;
         repeat (100) begin
            random_gap(gap_pct);
            send_random_word();
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      test_reset_and_edges();
      test_register_extremes();
      test_zero_durations();
      test_phase_cut();
      test_random_traffic();
      drain();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
